// ===== rtl/fbtp_pkg.sv =====
package fbtp_pkg;

  // Classified work handed from the front end to the packer.
  typedef enum logic [1:0] {
    OP_CODES = 2'd0,
    OP_ERROR = 2'd1,
    OP_PAD   = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic        two;   // second code present
    logic [4:0]  c0;
    logic [4:0]  c1;
    logic [7:0]  bad;   // offending byte for OP_ERROR
  } op_t;

  // Result kinds on the output channel
  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Fill states of the open word: empty, one code held, two codes held
  localparam logic [1:0] FILL_EMPTY = 2'd2;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_TWO   = 2'd0;

  localparam logic [7:0] LOWER_BIAS = 8'd91;
  localparam logic [7:0] UPPER_BIAS = 8'd59;
  localparam logic [7:0] DIGIT_BIAS = 8'd32;

endpackage

// ===== rtl/five_bit_text_packer.sv =====
// Five-bit text packer.
// Input channel (in_valid / in_stall, cmd, ch): one request per character
// byte, or cmd high to close the open word, padding it with zero codes.
// Output channel (out_valid / out_stall, kind, packed_word, bad_char): one
// request per finished word of three 5-bit codes in bits 15..1, or an error
// request (kind high) naming the byte that followed an illegal accent prefix.
// Accent prefixes and characters that only part-fill a word give no result.
// Throughput: one input request per clock while the queue has room; each
// request yields at most one result, so while the receiver does not stall
// the packer drains the queue as fast as the front fills it. With the queue
// empty and the output free, an accepted request is first written into the
// queue, then moved through the packer into the output register, where its
// result is presented.
// When the receiver stalls, the output register holds its request; the
// packer stops, the queue fills, and in_stall rises once the queue (QUEUE_DEPTH
// entries) is full. Reset empties the queue and output register, clears any
// pending accent and leaves the open word empty.
module five_bit_text_packer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [15:0] packed_word,
  output logic [7:0]  bad_char
);

  logic          accept;
  logic          push;
  fbtp_pkg::op_t push_op;
  logic          q_full;
  logic          q_valid;
  fbtp_pkg::op_t q_op;
  logic          pop;

  // Take a request whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Front: track accent prefixes and turn each byte into codes
  fbtp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .ch     (ch),
    .push   (push),
    .op     (push_op)
  );

  // Queue: decouple classification from packing
  fbtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push && accept),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  // Back: place codes into the open word and present results
  fbtp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_op        (q_op),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .packed_word (packed_word),
    .bad_char    (bad_char)
  );

endmodule

// ===== rtl/fbtp_front.sv =====
module fbtp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             cmd,
  input  logic [7:0]       ch,
  output logic             push,
  output fbtp_pkg::op_t    op
);

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_CIRC  = 2'd1,
    ACC_TILDE = 2'd2
  } acc_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LE      = 8'h65;
  localparam logic [7:0] CH_LI      = 8'h69;
  localparam logic [7:0] CH_LO      = 8'h6F;
  localparam logic [7:0] CH_LU      = 8'h75;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_D0      = 8'h30;
  localparam logic [7:0] CH_D9      = 8'h39;

  // Punctuation table: {hit, code}
  function automatic logic [5:0] punct(input logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      8'h21:   r = {1'b1, 5'd1};
      8'h22:   r = {1'b1, 5'd2};
      8'h7C:   r = {1'b1, 5'd4};
      8'h25:   r = {1'b1, 5'd5};
      8'h26:   r = {1'b1, 5'd6};
      8'h27:   r = {1'b1, 5'd7};
      8'h28:   r = {1'b1, 5'd8};
      8'h29:   r = {1'b1, 5'd9};
      8'h2B:   r = {1'b1, 5'd11};
      8'h2C:   r = {1'b1, 5'd12};
      8'h2D:   r = {1'b1, 5'd13};
      8'h2E:   r = {1'b1, 5'd14};
      8'h5C:   r = {1'b1, 5'd15};
      8'h3A:   r = {1'b1, 5'd26};
      8'h3B:   r = {1'b1, 5'd27};
      8'h3C:   r = {1'b1, 5'd28};
      8'h3D:   r = {1'b1, 5'd29};
      8'h5B:   r = {1'b1, 5'd30};
      8'h3F:   r = {1'b1, 5'd31};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  acc_t       pending, pending_next;
  logic [7:0] lower_diff, upper_diff, digit_diff;
  logic [5:0] pc;

  assign lower_diff = ch - fbtp_pkg::LOWER_BIAS;
  assign upper_diff = ch - fbtp_pkg::UPPER_BIAS;
  assign digit_diff = ch - fbtp_pkg::DIGIT_BIAS;
  assign pc         = punct(ch);

  always_comb begin
    pending_next = pending;
    push         = 1'b0;
    op.kind      = fbtp_pkg::OP_CODES;
    op.two       = 1'b0;
    op.c0        = 5'd0;
    op.c1        = 5'd0;
    op.bad       = ch;
    if (cmd) begin
      pending_next = ACC_NONE;
      push         = 1'b1;
      op.kind      = fbtp_pkg::OP_PAD;
    end else if (pending != ACC_NONE) begin
      pending_next = ACC_NONE;
      push         = 1'b1;
      op.two       = 1'b1;
      op.kind      = fbtp_pkg::OP_ERROR;
      if (pending == ACC_CIRC) begin
        priority if (ch == CH_LA) begin
          op.kind = fbtp_pkg::OP_CODES; op.c0 = 5'd0; op.c1 = 5'd3;
        end else if (ch == CH_LE) begin
          op.kind = fbtp_pkg::OP_CODES; op.c0 = 5'd1; op.c1 = 5'd0;
        end else if (ch == CH_LI) begin
          op.kind = fbtp_pkg::OP_CODES; op.c0 = 5'd1; op.c1 = 5'd2;
        end else if (ch == CH_LO) begin
          op.kind = fbtp_pkg::OP_CODES; op.c0 = 5'd0; op.c1 = 5'd10;
        end else if (ch == CH_LU) begin
          op.kind = fbtp_pkg::OP_CODES; op.c0 = 5'd1; op.c1 = 5'd4;
        end else begin
          op.kind = fbtp_pkg::OP_ERROR;
        end
      end else begin
        priority if (ch == CH_LE) begin
          op.kind = fbtp_pkg::OP_CODES; op.c0 = 5'd1; op.c1 = 5'd1;
        end else if (ch == CH_LI) begin
          op.kind = fbtp_pkg::OP_CODES; op.c0 = 5'd1; op.c1 = 5'd3;
        end else if (ch == CH_LU) begin
          op.kind = fbtp_pkg::OP_CODES; op.c0 = 5'd1; op.c1 = 5'd5;
        end else begin
          op.kind = fbtp_pkg::OP_ERROR;
        end
      end
    end else if (ch == CH_CARET) begin
      pending_next = ACC_CIRC;
    end else if (ch == CH_TILDE) begin
      pending_next = ACC_TILDE;
    end else begin
      push = 1'b1;
      priority if (ch >= CH_LA && ch <= CH_LZ) begin
        op.c0 = lower_diff[4:0];
      end else if (ch == CH_SPACE) begin
        op.c0 = 5'd2;
      end else if (ch == CH_AT) begin
        op.c0 = 5'd3;
      end else if (ch == CH_LBRACE) begin
        op.c0 = 5'd4;
      end else if (ch == CH_RBRACE) begin
        op.c0 = 5'd5;
      end else if (ch == CH_NEWLINE) begin
        op.two = 1'b1;
      end else if (ch >= CH_UA && ch <= CH_UZ) begin
        op.two = 1'b1; op.c0 = 5'd1; op.c1 = upper_diff[4:0];
      end else if (ch >= CH_D0 && ch <= CH_D9) begin
        op.two = 1'b1; op.c1 = digit_diff[4:0];
      end else if (pc[5]) begin
        op.two = 1'b1; op.c1 = pc[4:0];
      end else begin
        // unmatched byte: shift 0 alone
        op.two = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= ACC_NONE;
    end else if (accept) begin
      pending <= pending_next;
    end
  end

endmodule

// ===== rtl/fbtp_queue.sv =====
module fbtp_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fbtp_pkg::op_t    push_op,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output fbtp_pkg::op_t    q_op
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  fbtp_pkg::op_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");

endmodule

// ===== rtl/fbtp_back.sv =====
module fbtp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  fbtp_pkg::op_t    q_op,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             kind,
  output logic [15:0]      packed_word,
  output logic [7:0]       bad_char
);

  logic [1:0]  fill, fill_next;
  logic [9:0]  partial, partial_next;
  logic        emit;
  logic        emit_kind;
  logic [15:0] emit_word;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    fill_next    = fill;
    partial_next = partial;
    emit         = 1'b0;
    emit_kind    = fbtp_pkg::KIND_WORD;
    emit_word    = 16'd0;
    unique case (q_op.kind)
      fbtp_pkg::OP_ERROR: begin
        emit      = 1'b1;
        emit_kind = fbtp_pkg::KIND_ERROR;
      end
      fbtp_pkg::OP_PAD: begin
        fill_next    = fbtp_pkg::FILL_EMPTY;
        partial_next = 10'd0;
        emit         = (fill != fbtp_pkg::FILL_EMPTY);
        emit_word    = {partial, 6'd0};
      end
      fbtp_pkg::OP_CODES: begin
        unique case (fill)
          fbtp_pkg::FILL_EMPTY: begin
            partial_next = {q_op.c0, q_op.two ? q_op.c1 : 5'd0};
            fill_next    = q_op.two ? fbtp_pkg::FILL_TWO : fbtp_pkg::FILL_ONE;
          end
          fbtp_pkg::FILL_ONE: begin
            if (q_op.two) begin
              emit         = 1'b1;
              emit_word    = {partial[9:5], q_op.c0, q_op.c1, 1'b0};
              partial_next = 10'd0;
              fill_next    = fbtp_pkg::FILL_EMPTY;
            end else begin
              partial_next = {partial[9:5], q_op.c0};
              fill_next    = fbtp_pkg::FILL_TWO;
            end
          end
          fbtp_pkg::FILL_TWO: begin
            emit         = 1'b1;
            emit_word    = {partial, q_op.c0, 1'b0};
            partial_next = q_op.two ? {q_op.c1, 5'd0} : 10'd0;
            fill_next    = q_op.two ? fbtp_pkg::FILL_ONE : fbtp_pkg::FILL_EMPTY;
          end
          default: begin
            fill_next = fbtp_pkg::FILL_EMPTY;
          end
        endcase
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fill      <= fbtp_pkg::FILL_EMPTY;
      partial   <= 10'd0;
    end else begin
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        fill    <= fill_next;
        partial <= partial_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind        <= emit_kind;
      packed_word <= emit_word;
      bad_char    <= (emit_kind == fbtp_pkg::KIND_ERROR) ? q_op.bad : 8'd0;
    end
  end

  a_err_zero_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == fbtp_pkg::KIND_ERROR |-> packed_word == 16'd0)
    else $error("error result carries a word");
  a_word_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == fbtp_pkg::KIND_WORD |-> !packed_word[0] && bad_char == 8'd0)
    else $error("packed word malformed");
  a_fill_legal: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("fill position out of range");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !pop)
    else $error("packer advanced into a held result");

endmodule

// ===== sim/packed_text_checker.sv =====
module packed_text_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  ch,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic [15:0] packed_word,
  input  logic [7:0]  bad_char,
  output int          mismatches,
  output int          open_results,
  output int          words_seen,
  output int          errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CIRCUMFLEX = "^";
  localparam logic [7:0] TILDE      = "~";
  localparam logic [7:0] NEWLINE    = 8'd10;
  localparam int         REPORT_MAX = 10;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_CIRC  = 2'd1,
    ACC_TILDE = 2'd2
  } accent_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic [7:0]  bad;
  } result_t;

  result_t     expected_q[$];
  accent_t     accent;
  logic [1:0]  slots;
  logic [9:0]  held;
  logic [15:0] done_word;

  function automatic int punct_code(input logic [7:0] b);
    case (b)
      "!":  return 1;
      "\"": return 2;
      "|":  return 4;
      "%":  return 5;
      "&":  return 6;
      "'":  return 7;
      "(":  return 8;
      ")":  return 9;
      "+":  return 11;
      ",":  return 12;
      "-":  return 13;
      ".":  return 14;
      "\\": return 15;
      ":":  return 26;
      ";":  return 27;
      "<":  return 28;
      "=":  return 29;
      "[":  return 30;
      "?":  return 31;
      default: return -1;
    endcase
  endfunction

  // Codes of an unaccented byte; returns how many (1 or 2).
  function automatic int plain_codes(input logic [7:0] b, output logic [4:0] c0,
                                     output logic [4:0] c1);
    int p;
    c0 = '0;
    c1 = '0;
    if (b >= "a" && b <= "z") begin
      c0 = 5'(b - fbtp_pkg::LOWER_BIAS);
      return 1;
    end
    if (b == " ") begin
      c0 = 5'd2;
      return 1;
    end
    if (b == "@") begin
      c0 = 5'd3;
      return 1;
    end
    if (b == "{") begin
      c0 = 5'd4;
      return 1;
    end
    if (b == "}") begin
      c0 = 5'd5;
      return 1;
    end
    if (b == NEWLINE) return 2;
    if (b >= "A" && b <= "Z") begin
      c0 = 5'd1;
      c1 = 5'(b - fbtp_pkg::UPPER_BIAS);
      return 2;
    end
    if (b >= "0" && b <= "9") begin
      c1 = 5'(b - fbtp_pkg::DIGIT_BIAS);
      return 2;
    end
    p = punct_code(b);
    if (p >= 0) begin
      c1 = 5'(p);
      return 2;
    end
    // unmatched byte: shift 0 alone
    return 1;
  endfunction

  // Codes of an accented vowel; 0 flags an illegal pairing.
  function automatic int accent_codes(input accent_t a, input logic [7:0] b,
                                      output logic [4:0] c0, output logic [4:0] c1);
    c0 = '0;
    c1 = '0;
    if (a == ACC_CIRC) begin
      case (b)
        "a": begin c1 = 5'd3; return 2; end
        "e": begin c0 = 5'd1; return 2; end
        "i": begin c0 = 5'd1; c1 = 5'd2; return 2; end
        "o": begin c1 = 5'd10; return 2; end
        "u": begin c0 = 5'd1; c1 = 5'd4; return 2; end
        default: return 0;
      endcase
    end
    case (b)
      "e": begin c0 = 5'd1; c1 = 5'd1; return 2; end
      "i": begin c0 = 5'd1; c1 = 5'd3; return 2; end
      "u": begin c0 = 5'd1; c1 = 5'd5; return 2; end
      default: return 0;
    endcase
  endfunction

  // Drop one code into the open word; raise fin when the word closes.
  task automatic place_code(input logic [4:0] c, output logic fin);
    fin = 1'b0;
    case (slots)
      fbtp_pkg::FILL_EMPTY: begin
        held  = {c, 5'd0};
        slots = fbtp_pkg::FILL_ONE;
      end
      fbtp_pkg::FILL_ONE: begin
        held[4:0] = c;
        slots     = fbtp_pkg::FILL_TWO;
      end
      default: begin
        done_word = {held, c, 1'b0};
        held      = '0;
        slots     = fbtp_pkg::FILL_EMPTY;
        fin       = 1'b1;
      end
    endcase
  endtask

  // cmd high is a pad request; ch is then ignored.
  task automatic predict_request(input logic pad, input logic [7:0] b);
    logic [4:0] c0, c1;
    logic       fin, closed;
    int         n;
    closed = 1'b0;
    n      = 0;
    c0     = '0;
    c1     = '0;
    if (pad) begin
      accent = ACC_NONE;
      while (slots != fbtp_pkg::FILL_EMPTY && !closed) begin
        place_code(5'd0, fin);
        closed = fin;
      end
    end else if (accent != ACC_NONE) begin
      n      = accent_codes(accent, b, c0, c1);
      accent = ACC_NONE;
      if (n == 0) begin
        expected_q.push_back(result_t'{fbtp_pkg::KIND_ERROR, 16'd0, b});
        return;
      end
    end else if (b == CIRCUMFLEX) begin
      accent = ACC_CIRC;
      return;
    end else if (b == TILDE) begin
      accent = ACC_TILDE;
      return;
    end else begin
      n = plain_codes(b, c0, c1);
    end
    if (n >= 1) begin
      place_code(c0, fin);
      closed |= fin;
    end
    if (n == 2) begin
      place_code(c1, fin);
      closed |= fin;
    end
    if (closed) expected_q.push_back(result_t'{fbtp_pkg::KIND_WORD, done_word, 8'd0});
  endtask

  always @(posedge clk) begin : watch
    result_t got, want;
    got = result_t'{kind, packed_word, bad_char};
    if (rst) begin
      expected_q.delete();
      accent = ACC_NONE;
      slots  = fbtp_pkg::FILL_EMPTY;
      held   = '0;
    end else begin
      // compare before predicting: a result never belongs to this edge's request
      if (out_valid && !out_stall) begin
        if (got.kind == fbtp_pkg::KIND_ERROR) errors_seen++;
        else words_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%t: unexpected result kind=%0b word=%h bad=%h",
                     $realtime, got.kind, got.word, got.bad);
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind || got.word !== want.word || got.bad !== want.bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%t: mismatch expected kind=%0b word=%h bad=%h, got kind=%0b word=%h bad=%h",
                       $realtime, want.kind, want.word, want.bad,
                       got.kind, got.word, got.bad);
          end
        end
      end
      if (in_valid && !in_stall) predict_request(cmd, ch);
    end
    open_results = expected_q.size();
  end

endmodule

// ===== sim/tb_five_bit_text_packer.sv =====
module tb_five_bit_text_packer;
  timeunit 1ns;
  timeprecision 1ps;

  // Request kinds on the input channel
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_PAD  = 1'b1;

  localparam logic [7:0] CIRCUMFLEX = "^";
  localparam logic [7:0] TILDE      = "~";
  localparam logic [7:0] NEWLINE    = 8'd10;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int HOLD_CYCLES     = 200;   // long receiver hold-off to fill the block
  localparam int IDLE_LIMIT      = 2000;  // cycles without any handshake
  localparam int SETTLE_CYCLES   = 20;    // leave ample margin for stray results

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        cmd       = CMD_CHAR;
  logic [7:0]  ch        = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [15:0] packed_word;
  logic [7:0]  bad_char;

  int mismatches, open_results, words_seen, errors_seen;
  int sent        = 0;
  int pads_sent   = 0;
  int idle_cycles = 0;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;

  // Character pools for well-formed text
  string punct_chars = "!\"|%&'()+,-.\\:;<=[?@{}";
  string circ_vowels = "aeiou";
  string tilde_vowels = "eiu";

  initial begin
    forever #4 clk = ~clk;
  end

  five_bit_text_packer DUT (.*);

  packed_text_checker checker_i (.*);

  // Offer one request from the falling edge; hold it until it is taken.
  task automatic offer(input logic c, input logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      // idle with junk on the payload so nothing leaks from a dead cycle
      in_valid = 1'b0;
      cmd      = 1'($urandom_range(0, 1));
      ch       = 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd      = c;
    ch       = b;
    do @(posedge clk); while (in_stall);
    sent++;
    if (c == CMD_PAD) pads_sent++;
    @(negedge clk);
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++) offer(CMD_CHAR, s[i]);
  endtask

  // Receiver: draw a stall before every result, and twice hold off for a long
  // stretch while the sender keeps pushing, so that the queue fills and
  // in_stall rises.
  initial begin : drain
    int gap;
    int taken;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 99) == 0) rx_quiet = !rx_quiet;
      if (taken == 150 || taken == 500) gap = HOLD_CYCLES;
      else gap = rx_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // Watchdog: give up once neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_five_bit_text_packer NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int pick;
    int target;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: both ends of the lowercase range and the single-code marks
    offer_text("az @{}");
    // uppercase, digit, punctuation and newline, all two-code characters
    offer_text("A0?\n");
    // unmatched bytes, top and bottom of the range, emit shift 0 alone
    offer(CMD_CHAR, 8'hFF);
    offer(CMD_CHAR, 8'h00);
    offer(CMD_CHAR, 8'h80);
    // legal accents of both kinds, then illegal pairings (a prefix after a prefix too)
    offer_text("^o~u");
    offer_text("^q~~");
    // pad while an accent is pending clears it and closes the open word
    offer_text("^");
    offer(CMD_PAD, 8'hFF);
    // pad a part-filled word, then pad an empty one (no result)
    offer_text("}");
    offer(CMD_PAD, 8'h00);
    offer(CMD_PAD, 8'hA5);

    // Random: mostly well-formed text, some noise and broken accent pairs
    target = sent + RANDOM_REQUESTS;
    while (sent < target) begin
      if ($urandom_range(0, 149) == 0) tx_quiet = !tx_quiet;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        offer(CMD_CHAR, 8'("a" + $urandom_range(0, 25)));
      end else if (pick < 50) begin
        offer(CMD_CHAR, " ");
      end else if (pick < 58) begin
        offer(CMD_CHAR, 8'("A" + $urandom_range(0, 25)));
      end else if (pick < 64) begin
        offer(CMD_CHAR, 8'("0" + $urandom_range(0, 9)));
      end else if (pick < 70) begin
        offer(CMD_CHAR, punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
      end else if (pick < 73) begin
        offer(CMD_CHAR, NEWLINE);
      end else if (pick < 81) begin
        if ($urandom_range(0, 1)) begin
          offer(CMD_CHAR, CIRCUMFLEX);
          offer(CMD_CHAR, circ_vowels[$urandom_range(0, 4)]);
        end else begin
          offer(CMD_CHAR, TILDE);
          offer(CMD_CHAR, tilde_vowels[$urandom_range(0, 2)]);
        end
      end else if (pick < 84) begin
        // broken pair: any byte after a prefix, mostly illegal
        offer(CMD_CHAR, $urandom_range(0, 1) ? CIRCUMFLEX : TILDE);
        offer(CMD_CHAR, 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        offer(CMD_CHAR, 8'($urandom_range(0, 255)));
      end else if (pick < 91) begin
        offer(CMD_CHAR, 8'($urandom_range(128, 255)));
      end else if (pick < 97) begin
        offer(CMD_PAD, 8'($urandom_range(0, 255)));
      end else begin
        // pad straight after a prefix
        offer(CMD_CHAR, $urandom_range(0, 1) ? CIRCUMFLEX : TILDE);
        offer(CMD_PAD, 8'($urandom_range(0, 255)));
      end
    end
    in_valid = 1'b0;

    // Drain: wait for every predicted result, then watch for strays.
    while (open_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d requests (%0d pads) under random gaps and two long hold-offs;",
             sent, pads_sent);
    $display("checked %0d packed words and %0d accent errors, %0d mismatching.",
             words_seen, errors_seen, mismatches);
    if (mismatches == 0 && open_results == 0) begin
      $display("tb_five_bit_text_packer OK");
    end else begin
      $display("tb_five_bit_text_packer NOT OK");
    end
    $finish;
  end

endmodule
